[design/wta_pkg.sv]
// Package for the windowed trapezoid average block.
// Holds the register indexes, the controller states and the command and status structs.
// Used by wta_ctrl, wta_dp and windowed_trapezoid_average.
package wta_pkg;

  localparam int unsigned TIME_W     = 32;
  localparam int unsigned VALUE_W    = 24;
  localparam int unsigned AREA_W     = 64;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_START = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_END   = 1'b1;

  localparam int unsigned DIV_STEPS  = AREA_W;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ACC,
    S_CHECK,
    S_DIV,
    S_OUT
  } wta_state_t;

  typedef struct packed {
    logic capture;
    logic mul;
    logic acc;
    logic check;
    logic div_step;
    logic load_out;
  } wta_cmd_t;

  typedef struct packed {
    logic last;
    logic span_ok;
    logic out_free;
  } wta_sts_t;

endpackage

[design/wta_ctrl.sv]
// Controller of the windowed trapezoid average block.
// Sequences capture, multiply, accumulate and the iterative division.
// Depends on wta_pkg.
module wta_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  output logic               sample_stall,
  input  wta_pkg::wta_sts_t  sts,
  output wta_pkg::wta_cmd_t  cmd
);
  import wta_pkg::*;

  wta_state_t            state;
  wta_state_t            state_next;
  logic [DIV_CNT_W-1:0]  div_cnt;
  logic [DIV_CNT_W-1:0]  div_cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      div_cnt <= '0;
    end else begin
      state   <= state_next;
      div_cnt <= div_cnt_next;
    end
  end

  always_comb begin
    state_next   = state;
    div_cnt_next = div_cnt;
    cmd          = '0;
    sample_stall = 1'b1;
    case (state)
      S_IDLE: begin
        sample_stall = 1'b0;
        if (sample_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc    = 1'b1;
        state_next = sts.last ? S_CHECK : S_IDLE;
      end
      S_CHECK: begin
        cmd.check    = 1'b1;
        div_cnt_next = '0;
        state_next   = sts.span_ok ? S_DIV : S_OUT;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_next = div_cnt + 1'b1;
        if (div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[design/wta_dp.sv]
// Datapath of the windowed trapezoid average block.
// Holds the window registers, the running area, the restoring divider and the result register.
// Depends on wta_pkg.
module wta_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [wta_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [wta_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic [wta_pkg::TIME_W-1:0]           sample_time,
  input  logic signed [wta_pkg::VALUE_W-1:0]   sample_value,
  input  logic                                 last_sample,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic signed [wta_pkg::VALUE_W-1:0]   average,
  output logic                                 status,
  input  wta_pkg::wta_cmd_t                    cmd,
  output wta_pkg::wta_sts_t                    sts
);
  import wta_pkg::*;

  localparam int unsigned SUM_W  = VALUE_W + 1;
  localparam int unsigned PROD_W = SUM_W + TIME_W + 1;
  localparam int unsigned DIV_W  = TIME_W + 1;

  logic [TIME_W-1:0]         window_start;
  logic [TIME_W-1:0]         window_end;

  logic [TIME_W-1:0]         cur_time;
  logic signed [VALUE_W-1:0] cur_value;
  logic                      cur_last;

  logic                      kept;
  logic                      add_en;
  logic signed [PROD_W-1:0]  product;

  logic                      have_first;
  logic [TIME_W-1:0]         first_time;
  logic [TIME_W-1:0]         prev_time;
  logic signed [VALUE_W-1:0] prev_value;
  logic signed [AREA_W-1:0]  double_area;

  logic signed [SUM_W-1:0]   val_sum;
  logic [TIME_W-1:0]         dt;
  logic signed [AREA_W:0]    area_sum;
  logic signed [AREA_W-1:0]  area_sat;
  logic                      span_ok;

  logic [AREA_W-1:0]         div_q;
  logic [DIV_W-1:0]          div_r;
  logic [DIV_W-1:0]          div_d;
  logic                      div_neg;
  logic                      res_status;
  logic [DIV_W:0]            r_shift;
  logic [VALUE_W-1:0]        avg_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_start <= '0;
      window_end   <= '1;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_WINDOW_START: window_start <= cfg_data[TIME_W-1:0];
        REG_WINDOW_END:   window_end   <= cfg_data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_time  <= sample_time;
      cur_value <= sample_value;
      cur_last  <= last_sample;
    end
  end

  assign val_sum = {prev_value[VALUE_W-1], prev_value} + {cur_value[VALUE_W-1], cur_value};
  assign dt      = cur_time - prev_time;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      kept    <= (cur_time >= window_start) && (cur_time <= window_end);
      add_en  <= have_first && (cur_time > prev_time);
      product <= val_sum * $signed({1'b0, dt});
    end
  end

  assign area_sum = {double_area[AREA_W-1], double_area}
                  + {{(AREA_W + 1 - PROD_W){product[PROD_W-1]}}, product};

  always_comb begin
    if (area_sum[AREA_W] != area_sum[AREA_W-1]) begin
      area_sat = area_sum[AREA_W] ? {1'b1, {(AREA_W-1){1'b0}}} : {1'b0, {(AREA_W-1){1'b1}}};
    end else begin
      area_sat = area_sum[AREA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.load_out) begin
      have_first  <= 1'b0;
      first_time  <= '0;
      prev_time   <= '0;
      prev_value  <= '0;
      double_area <= '0;
    end else if (cmd.acc && kept) begin
      if (add_en) begin
        double_area <= area_sat;
      end
      if (!have_first) begin
        have_first <= 1'b1;
        first_time <= cur_time;
      end
      prev_time  <= cur_time;
      prev_value <= cur_value;
    end
  end

  assign span_ok = have_first && (prev_time > first_time);
  assign r_shift = {div_r, div_q[AREA_W-1]};

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      res_status <= !span_ok;
      div_q      <= double_area[AREA_W-1] ? -double_area : double_area;
      div_r      <= '0;
      div_d      <= {prev_time - first_time, 1'b0};
      div_neg    <= double_area[AREA_W-1];
    end else if (cmd.div_step) begin
      if (r_shift >= {1'b0, div_d}) begin
        div_r <= DIV_W'(r_shift - {1'b0, div_d});
        div_q <= {div_q[AREA_W-2:0], 1'b1};
      end else begin
        div_r <= r_shift[DIV_W-1:0];
        div_q <= {div_q[AREA_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    if (div_neg) begin
      if (div_q > AREA_W'(64'd8388608)) begin
        avg_sat = {1'b1, {(VALUE_W-1){1'b0}}};
      end else begin
        avg_sat = -div_q[VALUE_W-1:0];
      end
    end else begin
      if (div_q > AREA_W'(64'd8388607)) begin
        avg_sat = {1'b0, {(VALUE_W-1){1'b1}}};
      end else begin
        avg_sat = div_q[VALUE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load_out) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      average <= res_status ? '0 : $signed(avg_sat);
      status  <= res_status;
    end
  end

  assign sts.last     = cur_last;
  assign sts.span_ok  = span_ok;
  assign sts.out_free = !result_valid || !result_stall;

endmodule

[design/windowed_trapezoid_average.sv]
// Top level of the windowed trapezoid average block.
// Joins the controller wta_ctrl to the datapath wta_dp and carries the checks.
// Depends on wta_pkg, wta_ctrl and wta_dp.

// Each sample item passes through capture, one 25 by 33 bit multiply into a register,
// and the saturating accumulate. An item marked last then passes through the span check,
// the one-bit-a-cycle restoring divider and the load of the result register; the divider
// is skipped when there is no span to average over. The result register holds a
// finished item while the next samples are taken; only a further final item waits for it
// to be taken.
module windowed_trapezoid_average (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [wta_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [wta_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                 sample_valid,
  output logic                                 sample_stall,
  input  logic [wta_pkg::TIME_W-1:0]           sample_time,
  input  logic signed [wta_pkg::VALUE_W-1:0]   sample_value,
  input  logic                                 last_sample,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic signed [wta_pkg::VALUE_W-1:0]   average,
  output logic                                 status
);
  import wta_pkg::*;

  wta_cmd_t cmd;
  wta_sts_t sts;

  wta_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  wta_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_time  (sample_time),
    .sample_value (sample_value),
    .last_sample  (last_sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .average      (average),
    .status       (status),
    .cmd          (cmd),
    .sts          (sts)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (sample_valid && !sample_stall) |=> sample_stall)
    else $error("A sample item was taken while the previous one was still in work.");

  a_acc_after_mul: assert property (@(posedge clk) disable iff (rst)
    cmd.acc |-> $past(cmd.mul))
    else $error("The accumulate step ran without a fresh product.");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> sts.out_free)
    else $error("The result register was overwritten before its item was taken.");

  a_no_span_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status) |-> (average == '0))
    else $error("A result item without a span carries a nonzero average.");

endmodule

[tb/trapezoid_average_checker.sv]
// Checker for windowed_trapezoid_average: mirrors the window registers and the running
// trapezoid area, predicts each average and compares it with the results the block hands out.
// Depends on wta_pkg; instantiated by tb beside the block.
module trapezoid_average_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [wta_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [wta_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                 sample_valid,
  input  logic                                 sample_stall,
  input  logic [wta_pkg::TIME_W-1:0]           sample_time,
  input  logic signed [wta_pkg::VALUE_W-1:0]   sample_value,
  input  logic                                 last_sample,
  input  logic                                 result_valid,
  input  logic                                 result_stall,
  input  logic signed [wta_pkg::VALUE_W-1:0]   average,
  input  logic                                 status,
  output int                                   failures,
  output int                                   pending
);
  import wta_pkg::*;

  localparam longint AREA_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint AREA_MIN = -AREA_MAX - 64'sd1;
  localparam longint MEAN_MAX = 64'sd8388607;
  localparam longint MEAN_MIN = -64'sd8388608;

  typedef struct {
    logic signed [VALUE_W-1:0] average;
    logic                      status;
  } average_t;

  average_t averages_due[$];

  logic [TIME_W-1:0]          win_start;
  logic [TIME_W-1:0]          win_end;
  logic                       kept_any;
  logic [TIME_W-1:0]          first_t;
  logic [TIME_W-1:0]          latest_t;
  logic signed [VALUE_W-1:0]  latest_v;
  longint                     area_x2;

  task automatic clear_waveform();
    kept_any = 1'b0;
    first_t  = '0;
    latest_t = '0;
    latest_v = '0;
    area_x2  = 0;
  endtask

  task automatic absorb_sample(input logic [TIME_W-1:0] t, input logic signed [VALUE_W-1:0] v,
                               input logic fin);
    longint   slice;
    longint   span_x2;
    longint   mean;
    average_t due;
    if (t >= win_start && t <= win_end) begin
      if (kept_any) begin
        if (t > latest_t) begin
          slice = (longint'(latest_v) + longint'(v)) * longint'({32'h0, t - latest_t});
          if (slice > 0 && area_x2 > AREA_MAX - slice)
            area_x2 = AREA_MAX;
          else if (slice < 0 && area_x2 < AREA_MIN - slice)
            area_x2 = AREA_MIN;
          else
            area_x2 = area_x2 + slice;
        end
      end else begin
        kept_any = 1'b1;
        first_t  = t;
      end
      latest_t = t;
      latest_v = v;
    end
    if (fin) begin
      due.average = '0;
      due.status  = 1'b1;
      if (kept_any && latest_t > first_t) begin
        span_x2 = 2 * longint'({32'h0, latest_t - first_t});
        mean = area_x2 / span_x2;
        if (mean > MEAN_MAX) mean = MEAN_MAX;
        if (mean < MEAN_MIN) mean = MEAN_MIN;
        due.average = mean[VALUE_W-1:0];
        due.status  = 1'b0;
      end
      averages_due.push_back(due);
      clear_waveform();
    end
  endtask

  always @(posedge clk) begin
    average_t due;
    if (rst) begin
      win_start = '0;
      win_end   = '1;
      clear_waveform();
      averages_due.delete();
      failures = 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (averages_due.size() == 0) begin
          $display("%0t: result with none expected, got average %0d status %0d",
                   $time, average, status);
          failures = failures + 1;
        end else begin
          due = averages_due.pop_front();
          if (average !== due.average) begin
            $display("%0t: average expected %0d, got %0d", $time, due.average, average);
            failures = failures + 1;
          end
          if (status !== due.status) begin
            $display("%0t: status expected %0d, got %0d", $time, due.status, status);
            failures = failures + 1;
          end
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_WINDOW_START: win_start = cfg_data;
          REG_WINDOW_END:   win_end   = cfg_data;
          default: ;
        endcase
      end
      if (sample_valid && !sample_stall)
        absorb_sample(sample_time, sample_value, last_sample);
    end
    pending = averages_due.size();
  end

endmodule

[tb/tb.sv]
// Top of the testbench for windowed_trapezoid_average: clock, reset, window settings,
// sample waveforms and the stalling receiver; the verdict comes from the failure and pending counts.
// Depends on wta_pkg, windowed_trapezoid_average and trapezoid_average_checker.
module tb;
  import wta_pkg::*;

  localparam int DRAIN_CYCLES = 80;
  localparam int HOLD_CYCLES  = 400;
  localparam int QUIET_LIMIT  = 4000;
  localparam logic signed [VALUE_W-1:0] V_MAX = 24'sh7FFFFF;
  localparam logic signed [VALUE_W-1:0] V_MIN = 24'sh800000;

  logic                       clk;
  logic                       rst;
  logic                       cfg_write;
  logic [CFG_INDEX_W-1:0]     cfg_index;
  logic [CFG_DATA_W-1:0]      cfg_data;
  logic                       sample_valid;
  logic                       sample_stall;
  logic [TIME_W-1:0]          sample_time;
  logic signed [VALUE_W-1:0]  sample_value;
  logic                       last_sample;
  logic                       result_valid;
  logic                       result_stall;
  logic signed [VALUE_W-1:0]  average;
  logic                       status;
  int                         failures;
  int                         pending;

  int          send_idle = 26;
  int          recv_idle = 57;
  int          samples_sent = 0;
  int          quiet_cycles = 0;
  bit          hold_wanted = 1'b0;
  bit          hold_served = 1'b0;
  logic [31:0] cur_ws = '0;
  logic [31:0] cur_we = '1;

  windowed_trapezoid_average dut (.*);

  trapezoid_average_checker checker_i (.*);

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst || (sample_valid && !sample_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: random stalls, and once a long hold-off so that the block fills up.
  initial begin
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_wanted && !hold_served) begin
        hold_served = 1'b1;
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        result_stall <= ($urandom_range(99) < recv_idle);
      end
    end
  end

  task automatic send_sample(input logic [31:0] t, input logic signed [VALUE_W-1:0] v,
                             input logic fin);
    while ($urandom_range(99) < send_idle) begin
      sample_valid <= 1'b0;
      @(negedge clk);
    end
    sample_valid <= 1'b1;
    sample_time  <= t;
    sample_value <= v;
    last_sample  <= fin;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    samples_sent++;
    @(negedge clk);
  endtask

  task automatic settle();
    sample_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_window(input logic [31:0] ws, input logic [31:0] we);
    cfg_write <= 1'b1;
    cfg_index <= REG_WINDOW_START;
    cfg_data  <= ws;
    @(negedge clk);
    cfg_index <= REG_WINDOW_END;
    cfg_data  <= we;
    @(negedge clk);
    cfg_write <= 1'b0;
    cur_ws = ws;
    cur_we = we;
  endtask

  function automatic logic [31:0] start_time();
    case ($urandom_range(4))
      0: return $urandom;
      1: return cur_ws - $urandom_range(0, 20);
      2: return cur_ws + $urandom_range(0, 50);
      3: return cur_we - $urandom_range(0, 60);
      default: return cur_ws;
    endcase
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_value();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(9))
      0: return V_MAX;
      1: return V_MIN;
      2: return $signed(VALUE_W'($urandom_range(0, 20))) - 24'sd10;
      default: return r[VALUE_W-1:0];
    endcase
  endfunction

  // Mostly non-decreasing times with small steps; now and then a jump to a random time as noise.
  task automatic send_waveform(input int len);
    logic [31:0] t;
    logic [31:0] step;
    logic [32:0] nxt;
    int          k;
    t = start_time();
    for (k = 0; k < len; k++) begin
      if (k > 0) begin
        case ($urandom_range(9))
          0: step = '0;
          7: step = $urandom_range(1, 5000);
          8: step = $urandom >> $urandom_range(0, 31);
          default: step = $urandom_range(1, 16);
        endcase
        if ($urandom_range(19) == 0) begin
          t = $urandom;
        end else begin
          nxt = {1'b0, t} + {1'b0, step};
          t = nxt[32] ? 32'hFFFF_FFFF : nxt[31:0];
        end
      end
      send_sample(t, pick_value(), k == len - 1);
    end
  endtask

  task automatic run_segment(input logic [31:0] ws, input logic [31:0] we, input int count,
                             input int max_len, input bit pressure);
    int first;
    settle();
    set_window(ws, we);
    if (pressure) hold_wanted = 1'b1;
    first = samples_sent;
    while (samples_sent - first < count)
      send_waveform(($urandom_range(3) == 0) ? $urandom_range(1, max_len)
                                             : $urandom_range(1, 6));
  endtask

  // Alternating full-range time steps drive the doubled area into saturation.
  task automatic saturate_area(input logic signed [VALUE_W-1:0] v);
    send_sample(32'd0, v, 1'b0);
    repeat (130) begin
      send_sample(32'hFFFF_FFFF, v, 1'b0);
      send_sample(32'd0, v, 1'b0);
    end
    send_sample(32'd1, v, 1'b1);
  endtask

  function automatic logic [31:0] window_top(input logic [31:0] ws, input int span);
    logic [32:0] sum;
    sum = {1'b0, ws} + 33'(span);
    return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  endfunction

  initial begin
    logic [31:0] a;
    rst          = 1'b1;
    cfg_write    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    sample_valid = 1'b0;
    sample_time  = '0;
    sample_value = '0;
    last_sample  = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_sample(32'd0, 24'sd0, 1'b1);
    send_sample(32'd5, 24'sd100, 1'b0);
    send_sample(32'd5, 24'sd200, 1'b1);
    send_sample(32'd0, V_MAX, 1'b0);
    send_sample(32'hFFFF_FFFF, V_MAX, 1'b1);
    send_sample(32'd0, V_MIN, 1'b0);
    send_sample(32'hFFFF_FFFF, V_MIN, 1'b1);
    send_sample(32'd10, -24'sd7, 1'b0);
    send_sample(32'd11, 24'sd0, 1'b1);
    send_sample(32'd100, 24'sd5, 1'b0);
    send_sample(32'd50, 24'sd9, 1'b1);
    send_sample(32'd100, 24'sd1, 1'b0);
    send_sample(32'd40, 24'sd2, 1'b0);
    send_sample(32'd200, 24'sd3, 1'b1);
    settle();
    set_window(32'd100, 32'd200);
    send_sample(32'd50, 24'sd1, 1'b0);
    send_sample(32'd100, 24'sd10, 1'b0);
    send_sample(32'd150, 24'sd20, 1'b0);
    send_sample(32'd200, 24'sd30, 1'b0);
    send_sample(32'd201, 24'sd99, 1'b1);
    settle();
    set_window(32'd300, 32'd200);
    send_sample(32'd250, 24'sd1, 1'b0);
    send_sample(32'd250, 24'sd2, 1'b1);

    run_segment(32'd0, 32'hFFFF_FFFF, 60, 12, 1'b0);
    a = $urandom;
    run_segment(a, window_top(a, $urandom_range(1, 200000)), 50, 20, 1'b0);
    a = $urandom;
    run_segment(a, a, 40, 8, 1'b0);

    send_idle = 57;
    recv_idle = 26;
    a = $urandom | 32'h1;
    run_segment(a, a - 32'd1, 30, 6, 1'b0);
    run_segment(32'd0, 32'd0, 30, 6, 1'b0);
    run_segment(32'hFFFF_FFFF, 32'hFFFF_FFFF, 30, 6, 1'b0);
    a = $urandom;
    run_segment(a, window_top(a, $urandom_range(1, 5000)), 60, 16, 1'b0);

    send_idle = 0;
    recv_idle = 0;
    run_segment(32'd0, 32'hFFFF_FFFF, 60, 3, 1'b1);
    saturate_area(V_MAX);
    saturate_area(V_MIN);
    run_segment(32'd0, 32'hFFFF_FFFF, 40, 10, 1'b0);

    settle();
    if (failures == 0 && pending == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

[sim.f]
design/wta_pkg.sv
design/wta_ctrl.sv
design/wta_dp.sv
design/windowed_trapezoid_average.sv
tb/trapezoid_average_checker.sv
tb/tb.sv
